// ===== hw/rtl/msed_pkg.sv =====
// Shared types, entity table and sizing constants for the markup strip unit.
package msed_pkg;

   localparam int LenWidth   = 12;
   localparam int QueueDepth = 4;
   localparam int EntDepth   = 6;
   localparam int NumEnt     = 6;
   localparam int CfgWidth   = 12;
   localparam int CsrAddrW   = 3;

   localparam logic [7:0] CharAmp   = 8'h26;
   localparam logic [7:0] CharLt    = 8'h3C;
   localparam logic [7:0] CharGt    = 8'h3E;
   localparam logic [6:0] CharSpace = 7'h20;

   // Register index of max_out_len, taken from paddr[2].
   localparam logic RegMaxOutLen = 1'b0;

   // Byte i of each entity name sits at bits [8*i +: 8].
   localparam logic [0:NumEnt-1][8*EntDepth-1:0] ENT_TEXT = '{
      {8'h00, ";", "p", "m", "a", "&"},
      {8'h00, 8'h00, ";", "t", "l", "&"},
      {8'h00, 8'h00, ";", "t", "g", "&"},
      {";", "t", "o", "u", "q", "&"},
      {";", "s", "o", "p", "a", "&"},
      {";", "p", "s", "b", "n", "&"}
   };
   localparam logic [0:NumEnt-1][2:0] ENT_LEN = '{3'd5, 3'd4, 3'd4, 3'd6, 3'd6, 3'd6};
   localparam logic [0:NumEnt-1][6:0] ENT_VALUE = '{
      7'h26, 7'h3C, 7'h3E, 7'h22, 7'h27, CharSpace
   };

   typedef struct packed {
      logic [6:0] ch;
      logic       is_end;
   } msed_item_type;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_EVAL   = 4'b0010,
      S_REPLAY = 4'b0100,
      S_END    = 4'b1000
   } msed_state_type;

endpackage

// ===== hw/rtl/markup_strip_entity_decode_unit.sv =====
// Top level of the markup strip and entity decode unit with its register port.
//
// Input channel: push a source byte with req_in_byte and req_is_last while full
// is low. Result channel: while empty is low, rsp_out_char / rsp_is_end hold the
// oldest result; pop takes it. Each field ends with one item with rsp_is_end set.
// Register max_out_len sits at byte address 0 of the APB-style port (pready is
// always high); it caps the characters emitted per field, reset value 255.
// The front sequencer takes each byte through accept, then evaluate, and takes
// no new byte before it is back in idle. A broken entity match first emits '&'
// and replays the buffered letters before the breaking byte is evaluated again;
// a field end emits the terminator, after first flushing '&' and the buffered
// letters when lookahead is pending. A result passes from the held byte through
// a queue slot into the result register before it shows on the ports.
// The front and the result register are decoupled by a four-entry queue; when
// the receiver stalls, results collect there and then full rises to hold input.
// Reset (synchronous) empties the queue and result register and clears tag,
// lookahead and length count; no clearing pass is needed.
module markup_strip_entity_decode_unit #(
   parameter int LEN_WIDTH   = msed_pkg::LenWidth,
   parameter int QUEUE_DEPTH = msed_pkg::QueueDepth
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic [7:0]                    req_in_byte,
   input  logic                          req_is_last,
   output logic                          empty,
   input  logic                          pop,
   output logic [6:0]                    rsp_out_char,
   output logic                          rsp_is_end,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [msed_pkg::CsrAddrW-1:0] paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);

   logic [LEN_WIDTH-1:0]    max_len_ff, max_len_in;
   logic                    f_push, q_full, q_empty, q_pop;
   msed_pkg::msed_item_type f_item, h_item;
   logic                    reg_sel;

   assign pready  = 1'b1;
   assign reg_sel = (paddr[2] == msed_pkg::RegMaxOutLen);
   assign prdata  = reg_sel ? 32'(max_len_ff) : 32'd0;

   always_comb begin
      max_len_in = max_len_ff;
      if (psel && penable && pwrite && pready && reg_sel) begin
         max_len_in = LEN_WIDTH'(pwdata[msed_pkg::CfgWidth-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= LEN_WIDTH'(12'd255);
      end else begin
         max_len_ff <= max_len_in;
      end
   end

   msed_front u_front (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .full    (full),
      .in_byte (req_in_byte),
      .is_last (req_is_last),
      .q_push  (f_push),
      .q_item  (f_item),
      .q_full  (q_full)
   );

   msed_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (f_push),
      .wr_item (f_item),
      .q_full  (q_full),
      .rd_en   (q_pop),
      .rd_item (h_item),
      .q_empty (q_empty)
   );

   msed_back #(.LEN_WIDTH(LEN_WIDTH)) u_back (
      .clock       (clock),
      .reset       (reset),
      .max_out_len (max_len_ff),
      .q_item      (h_item),
      .q_empty     (q_empty),
      .q_pop       (q_pop),
      .out_char    (rsp_out_char),
      .is_end      (rsp_is_end),
      .empty       (empty),
      .pop         (pop)
   );

endmodule

// ===== hw/rtl/msed_front.sv =====
// Front end: accepts bytes, tracks tags and entity lookahead, pushes output events.
module msed_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  logic [7:0]             in_byte,
   input  logic                   is_last,
   output logic                   q_push,
   output msed_pkg::msed_item_type q_item,
   input  logic                   q_full
);

   msed_pkg::msed_state_type state_ff, state_in;
   logic [7:0] hold_byte_ff;
   logic       hold_last_ff;
   logic       inside_tag_ff, inside_tag_in;
   logic [2:0] fill_ff, fill_in;
   logic [2:0] idx_ff, idx_in;
   logic       end_flush_ff, end_flush_in;
   logic [7:0] ent_buf_ff [msed_pkg::EntDepth];
   logic       buf_we;
   logic [2:0] buf_wa;

   logic       ent_complete;
   logic       ent_prefix;
   logic [6:0] ent_value;
   logic       printable;

   assign full      = (state_ff != msed_pkg::S_IDLE);
   assign printable = !hold_byte_ff[7] && (hold_byte_ff[6:5] != 2'b00);

   // Compare the buffered prefix plus the held byte against every entity name.
   always_comb begin
      logic ok;
      ent_complete = 1'b0;
      ent_prefix   = 1'b0;
      ent_value    = 7'd0;
      for (int k = 0; k < msed_pkg::NumEnt; k++) begin
         ok = (({1'b0, fill_ff} + 4'd1) <= {1'b0, msed_pkg::ENT_LEN[k]});
         for (int i = 1; i < msed_pkg::EntDepth - 1; i++) begin
            if ((3'(i) < fill_ff) &&
                (ent_buf_ff[i] != msed_pkg::ENT_TEXT[k][8*i +: 8])) begin
               ok = 1'b0;
            end
         end
         if (msed_pkg::ENT_TEXT[k][{fill_ff, 3'b000} +: 8] != hold_byte_ff) begin
            ok = 1'b0;
         end
         if (ok) begin
            if (({1'b0, fill_ff} + 4'd1) == {1'b0, msed_pkg::ENT_LEN[k]}) begin
               ent_complete = 1'b1;
               ent_value    = msed_pkg::ENT_VALUE[k];
            end else begin
               ent_prefix = 1'b1;
            end
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      inside_tag_in = inside_tag_ff;
      fill_in       = fill_ff;
      idx_in        = idx_ff;
      end_flush_in  = end_flush_ff;
      buf_we        = 1'b0;
      buf_wa        = fill_ff;
      q_push        = 1'b0;
      q_item.ch     = 7'd0;
      q_item.is_end = 1'b0;
      case (state_ff)
         msed_pkg::S_IDLE: begin
            if (push) begin
               state_in = msed_pkg::S_EVAL;
            end
         end
         msed_pkg::S_EVAL: begin
            if (!q_full) begin
               state_in = msed_pkg::S_IDLE;
               if (fill_ff != 3'd0) begin
                  if (ent_complete) begin
                     q_push    = 1'b1;
                     q_item.ch = ent_value;
                     fill_in   = 3'd0;
                  end else if (ent_prefix) begin
                     buf_we  = 1'b1;
                     fill_in = fill_ff + 3'd1;
                  end else begin
                     // Broken match: emit '&', replay the letters, then re-evaluate.
                     q_push       = 1'b1;
                     q_item.ch    = msed_pkg::CharAmp[6:0];
                     idx_in       = 3'd1;
                     end_flush_in = 1'b0;
                     state_in     = msed_pkg::S_REPLAY;
                  end
               end else begin
                  if (hold_byte_ff == msed_pkg::CharLt) begin
                     inside_tag_in = 1'b1;
                  end else if (hold_byte_ff == msed_pkg::CharGt) begin
                     inside_tag_in = 1'b0;
                  end else if (inside_tag_ff) begin
                     // drop markup
                  end else if (hold_byte_ff == msed_pkg::CharAmp) begin
                     buf_we  = 1'b1;
                     buf_wa  = 3'd0;
                     fill_in = 3'd1;
                  end else if (printable) begin
                     q_push    = 1'b1;
                     q_item.ch = hold_byte_ff[6:0];
                  end
               end
               // Field end: flush pending lookahead, then close the field.
               if (hold_last_ff && (state_in == msed_pkg::S_IDLE)) begin
                  if (fill_in != 3'd0) begin
                     q_push       = 1'b1;
                     q_item.ch    = msed_pkg::CharAmp[6:0];
                     idx_in       = 3'd1;
                     end_flush_in = 1'b1;
                     state_in     = msed_pkg::S_REPLAY;
                  end else begin
                     state_in = msed_pkg::S_END;
                  end
               end
            end
         end
         msed_pkg::S_REPLAY: begin
            if (!q_full) begin
               if (idx_ff < fill_ff) begin
                  q_push    = 1'b1;
                  q_item.ch = ent_buf_ff[idx_ff][6:0];
                  idx_in    = idx_ff + 3'd1;
               end else begin
                  fill_in  = 3'd0;
                  state_in = end_flush_ff ? msed_pkg::S_END : msed_pkg::S_EVAL;
               end
            end
         end
         msed_pkg::S_END: begin
            if (!q_full) begin
               q_push        = 1'b1;
               q_item.is_end = 1'b1;
               inside_tag_in = 1'b0;
               fill_in       = 3'd0;
               state_in      = msed_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = msed_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= msed_pkg::S_IDLE;
         inside_tag_ff <= 1'b0;
         fill_ff       <= 3'd0;
         idx_ff        <= 3'd0;
         end_flush_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         inside_tag_ff <= inside_tag_in;
         fill_ff       <= fill_in;
         idx_ff        <= idx_in;
         end_flush_ff  <= end_flush_in;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == msed_pkg::S_IDLE) && push) begin
         hold_byte_ff <= in_byte;
         hold_last_ff <= is_last;
      end
      if (buf_we) begin
         ent_buf_ff[buf_wa] <= hold_byte_ff;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      fill_ff < 3'(msed_pkg::EntDepth))
      else $error("entity fill out of range");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == msed_pkg::S_END) && !q_full |=> (fill_ff == 3'd0) && !inside_tag_ff)
      else $error("field state not cleared after terminator");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == msed_pkg::S_IDLE) |-> !q_push)
      else $error("event pushed while idle");
`endif

endmodule

// ===== hw/rtl/msed_queue.sv =====
// Short register queue of output events between front and back.
module msed_queue #(
   parameter int DEPTH = msed_pkg::QueueDepth
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    wr_en,
   input  msed_pkg::msed_item_type wr_item,
   output logic                    q_full,
   input  logic                    rd_en,
   output msed_pkg::msed_item_type rd_item,
   output logic                    q_empty
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   msed_pkg::msed_item_type slot_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_wr, do_rd;

   assign q_full  = (count_ff == CntW'(DEPTH));
   assign q_empty = (count_ff == '0);
   assign do_wr   = wr_en && !q_full;
   assign do_rd   = rd_en && !q_empty;
   assign rd_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + CntW'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_item;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(DEPTH))
      else $error("queue count overflow");
   assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree when empty");
`endif

endmodule

// ===== hw/rtl/msed_back.sv =====
// Back end: applies the per-field length limit and holds the result register.
module msed_back #(
   parameter int LEN_WIDTH = msed_pkg::LenWidth
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [LEN_WIDTH-1:0]    max_out_len,
   input  msed_pkg::msed_item_type q_item,
   input  logic                    q_empty,
   output logic                    q_pop,
   output logic [6:0]              out_char,
   output logic                    is_end,
   output logic                    empty,
   input  logic                    pop
);

   logic                 out_valid_ff, out_valid_in;
   msed_pkg::msed_item_type out_ff;
   logic [LEN_WIDTH-1:0] count_ff, count_in;
   logic                 load;

   assign empty    = !out_valid_ff;
   assign out_char = out_ff.ch;
   assign is_end   = out_ff.is_end;

   always_comb begin
      q_pop    = !q_empty && (!out_valid_ff || pop);
      load     = 1'b0;
      count_in = count_ff;
      if (q_pop) begin
         if (q_item.is_end) begin
            load     = 1'b1;
            count_in = '0;
         end else if (count_ff < max_out_len) begin
            load     = 1'b1;
            count_in = count_ff + LEN_WIDTH'(1);
         end
         // otherwise drop the character past the limit
      end
      out_valid_in = out_valid_ff;
      if (load) begin
         out_valid_in = 1'b1;
      end else if (pop && out_valid_ff) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_ff <= q_item;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("pop from empty queue");
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !pop |=> $stable(out_ff) && out_valid_ff)
      else $error("held result changed");
`endif

endmodule
